// ===== sv/prqs_pkg.sv =====
`default_nettype none

package prqs_pkg;

   // Table size. The counters, indexes and scan length are all derived from it.
   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int TASK_W  = 13;
   localparam int PRIO_W  = 16;
   localparam int SLICE_W = 8;
   localparam int OCC_W   = 7;

   localparam logic [SLICE_W-1:0] MAX_SLICE_RESET = 8'd5;

   typedef enum logic [1:0] {
      KIND_ENQ  = 2'd0,
      KIND_DEQ  = 2'd1,
      KIND_PICK = 2'd2,
      KIND_TICK = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      kind_type            kind;
      logic [TASK_W-1:0]   task_id;
      logic [PRIO_W-1:0]   priority_req;
      logic [SLICE_W-1:0]  slice_in;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [TASK_W-1:0]   task_out;
      logic [PRIO_W-1:0]   priority_out;
      logic [SLICE_W-1:0]  slice_out;
      logic                resched_flag;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // One stored table entry.
   typedef struct packed {
      logic [TASK_W-1:0]   task_id;
      logic [PRIO_W-1:0]   prio;
      logic [SLICE_W-1:0]  slice;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic full;
      logic hit;
      logic last;
      logic slot_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/priority_ready_queue_scheduler_unit.sv =====
`default_nettype none

// Ready-queue table for a highest-priority-first scheduler, holding up to
// QUEUE_DEPTH tasks (64) with a task id, a priority and a time slice each.
// A request is one of enqueue, dequeue by id, pick (report the highest
// priority entry, smaller id on a tie, without removing it) and tick (count
// down the running task's slice and flag a reschedule at zero); each request
// gives exactly one response with a status, the task fields and the queue
// occupancy after the request. Enqueued slices of zero or above max_slice are
// stored as max_slice, which resets to 5; the user must write it through
// csr_we/csr_wdata only while the block is idle, which the block itself does
// not enforce. Requests are handled one at a time; the entries live in a
// memory with one write and one read port that is walked one entry per clock
// through a registered read. A pick walks the whole table, an enqueue walks up
// to the first free slot, a dequeue walks up to the matching slot (a miss
// walks the whole table), and a tick or an enqueue into a full table needs no
// walk. A finished response sits in an output register, so a new
// request may be accepted while the previous response is still stalled; the
// block only waits if a second response is ready before the first has been
// taken.
module priority_ready_queue_scheduler_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  prqs_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output prqs_pkg::rsp_type   rsp_data,
   input  wire                 csr_we,
   input  wire [7:0]           csr_wdata
);

   // Commands from the sequencer and status back from the table datapath.
   prqs_pkg::cmd_type  cmd;
   prqs_pkg::stat_type stat;

   // The sequencer accepts a request, runs the table walk and hands the
   // result to the output register once that register is free.
   prqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // The datapath holds the table, the valid bits, the count, the walk
   // pipeline, the best-candidate register and the response register.
   prqs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/prqs_ctrl.sv =====
`default_nettype none

module prqs_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  prqs_pkg::kind_type  req_kind,
   input  prqs_pkg::stat_type  stat,
   output logic                req_stall,
   output prqs_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               // A tick, or an enqueue into a full table, needs no table walk.
               if (req_kind == prqs_pkg::KIND_TICK) begin
                  state_in = S_DONE;
               end else if (req_kind == prqs_pkg::KIND_ENQ && stat.full) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit || stat.last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/prqs_datapath.sv =====
`default_nettype none

module prqs_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  prqs_pkg::cmd_type    cmd,
   input  prqs_pkg::req_type    req_data,
   input  wire                  csr_we,
   input  wire [7:0]            csr_wdata,
   input  wire                  rsp_stall,
   output prqs_pkg::stat_type   stat,
   output logic                 rsp_valid,
   output prqs_pkg::rsp_type    rsp_data
);

   localparam logic [prqs_pkg::IDX_W-1:0] LAST_IDX =
      prqs_pkg::IDX_W'(prqs_pkg::QUEUE_DEPTH - 1);
   localparam logic [prqs_pkg::CNT_W-1:0] FULL_CNT =
      prqs_pkg::CNT_W'(prqs_pkg::QUEUE_DEPTH);

   prqs_pkg::req_type               req_ff;
   logic [prqs_pkg::SLICE_W-1:0]    max_slice_ff;
   logic [prqs_pkg::QUEUE_DEPTH-1:0] valid_ff;
   logic [prqs_pkg::CNT_W-1:0]      count_ff;
   prqs_pkg::entry_type             mem [prqs_pkg::QUEUE_DEPTH];

   logic [prqs_pkg::IDX_W-1:0]      issue_idx_ff;
   logic                            s1_live_ff;
   logic [prqs_pkg::IDX_W-1:0]      s1_idx_ff;
   logic                            s1_vld_ff;
   prqs_pkg::entry_type             s1_data_ff;

   logic                            have_ff;
   prqs_pkg::entry_type             best_ff;

   logic                            rsp_valid_ff;
   prqs_pkg::rsp_type               rsp_data_ff;

   logic                            scan_eval;
   logic                            match_enq;
   logic                            match_deq;
   logic                            pick_upd;
   logic                            better;
   logic [prqs_pkg::SLICE_W-1:0]    clamped;
   logic [prqs_pkg::SLICE_W-1:0]    tick_slice;
   prqs_pkg::entry_type             wdata;
   prqs_pkg::rsp_type               result;

   assign clamped = (req_ff.slice_in == '0 || req_ff.slice_in > max_slice_ff) ?
                    max_slice_ff : req_ff.slice_in;
   assign tick_slice = (req_ff.slice_in != '0) ?
                       (req_ff.slice_in - prqs_pkg::SLICE_W'(1)) : '0;

   assign better = !have_ff ||
                   (s1_data_ff.prio > best_ff.prio) ||
                   (s1_data_ff.prio == best_ff.prio &&
                    s1_data_ff.task_id < best_ff.task_id);

   assign scan_eval = cmd.scan && s1_live_ff;
   assign match_enq = scan_eval && req_ff.kind == prqs_pkg::KIND_ENQ && !s1_vld_ff;
   assign match_deq = scan_eval && req_ff.kind == prqs_pkg::KIND_DEQ && s1_vld_ff &&
                      s1_data_ff.task_id == req_ff.task_id;
   assign pick_upd  = scan_eval && req_ff.kind == prqs_pkg::KIND_PICK && s1_vld_ff &&
                      better;

   assign stat.full      = (count_ff == FULL_CNT);
   assign stat.hit       = match_enq || match_deq;
   assign stat.last      = scan_eval && (s1_idx_ff == LAST_IDX);
   assign stat.slot_free = !rsp_valid_ff || !rsp_stall;

   assign wdata.task_id = req_ff.task_id;
   assign wdata.prio    = req_ff.priority_req;
   assign wdata.slice   = clamped;

   always_comb begin
      result.status       = prqs_pkg::ST_OK;
      result.task_out     = req_ff.task_id;
      result.priority_out = '0;
      result.slice_out    = '0;
      result.resched_flag = 1'b0;
      result.occupancy    = prqs_pkg::OCC_W'(count_ff);
      case (req_ff.kind)
         prqs_pkg::KIND_ENQ: begin
            result.status       = have_ff ? prqs_pkg::ST_OK : prqs_pkg::ST_FULL;
            result.priority_out = req_ff.priority_req;
            result.slice_out    = clamped;
         end
         prqs_pkg::KIND_DEQ: begin
            if (have_ff) begin
               result.task_out     = best_ff.task_id;
               result.priority_out = best_ff.prio;
               result.slice_out    = best_ff.slice;
            end else begin
               result.status = prqs_pkg::ST_NOTFOUND;
            end
         end
         prqs_pkg::KIND_PICK: begin
            if (have_ff) begin
               result.task_out     = best_ff.task_id;
               result.priority_out = best_ff.prio;
               result.slice_out    = best_ff.slice;
            end else begin
               result.status   = prqs_pkg::ST_EMPTY;
               result.task_out = '0;
            end
         end
         default: begin
            result.slice_out    = tick_slice;
            result.resched_flag = (tick_slice == '0);
         end
      endcase
   end

   // Table storage: one write port for enqueue, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (match_enq) begin
         mem[s1_idx_ff] <= wdata;
      end
      s1_data_ff <= mem[issue_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (match_deq || pick_upd) begin
         best_ff <= s1_data_ff;
      end
      s1_idx_ff <= issue_idx_ff;
      s1_vld_ff <= valid_ff[issue_idx_ff];
      if (cmd.finish) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_slice_ff <= prqs_pkg::MAX_SLICE_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         issue_idx_ff <= '0;
         s1_live_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_slice_ff <= csr_wdata;
         end
         if (match_enq) begin
            valid_ff[s1_idx_ff] <= 1'b1;
            count_ff            <= count_ff + prqs_pkg::CNT_W'(1);
         end else if (match_deq) begin
            valid_ff[s1_idx_ff] <= 1'b0;
            count_ff            <= count_ff - prqs_pkg::CNT_W'(1);
         end
         if (cmd.load) begin
            issue_idx_ff <= '0;
         end else if (cmd.scan && issue_idx_ff != LAST_IDX) begin
            issue_idx_ff <= issue_idx_ff + prqs_pkg::IDX_W'(1);
         end
         s1_live_ff <= cmd.scan;
         if (cmd.load) begin
            have_ff <= 1'b0;
         end else if (match_enq || match_deq || pick_upd) begin
            have_ff <= 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_enq_free_slot: assert property (@(posedge clock) disable iff (reset)
      match_enq |-> !valid_ff[s1_idx_ff])
      else $error("enqueue wrote over an occupied slot");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      match_deq |=> count_ff == $past(count_ff) - prqs_pkg::CNT_W'(1))
      else $error("dequeue did not lower the task count");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished request did not present a result");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !have_ff)
      else $error("stale match carried into a new request");

endmodule

`default_nettype wire
